@@ rtl/core/crpp_pkg.sv @@
`default_nettype none
package crpp_pkg;
    localparam int MAX_POINTS_DEF  = 64;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int PROG_W = 18;
    localparam int T_W    = 17;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_RSVD   = 2'd3;

    localparam logic [1:0] ST_VALID = 2'd0;
    localparam logic [1:0] ST_FEW   = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic [T_W-1:0] ONE_Q16 = 17'h10000;
endpackage
`default_nettype wire

@@ rtl/core/catmull_rom_path_position.sv @@
`default_nettype none
// Catmull-Rom path position unit.
// Drive command and its fields with start high while busy is low; the
// command is taken at that edge. Commands: clear, append a Q16.16 point,
// query the position at a Q2.16 progress value.
// Clear, append, the unused code and a query on fewer than four points
// answer with done in the cycle after the transfer and may follow back to back.
// A full query passes through scale, index set-up, serial reads of the
// four points through the one read port of the point memory (registered
// read), coefficient load, three Horner steps and the output step, and
// answers in the cycle after the output step; reads and Horner steps dominate.
// busy is high from scale to the output step of a query; one command at a time.
// Each result is shown on pos_x/y/z and status for one cycle with done
// high; the receiver cannot stall, so no result is buffered for it.
// looping is written with cfg_we/cfg_data while idle, taking effect at the
// next query. Reset clears the point count, looping and the sequencer; the
// point memory holds no reset and needs no clearing.
module catmull_rom_path_position #(
    parameter int MAX_POINTS  = crpp_pkg::MAX_POINTS_DEF,
    parameter int COORD_WIDTH = crpp_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_data,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    command,
    input  wire logic signed [COORD_WIDTH-1:0] point_x,
    input  wire logic signed [COORD_WIDTH-1:0] point_y,
    input  wire logic signed [COORD_WIDTH-1:0] point_z,
    input  wire logic signed [crpp_pkg::PROG_W-1:0] progress,
    output logic                               done,
    output logic signed [COORD_WIDTH-1:0]      pos_x,
    output logic signed [COORD_WIDTH-1:0]      pos_y,
    output logic signed [COORD_WIDTH-1:0]      pos_z,
    output logic [1:0]                         status
);
    localparam int IW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int SW = NW + crpp_pkg::T_W;
    localparam int CW = COORD_WIDTH;
    localparam int TW = crpp_pkg::T_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCALE = 7'b0000010,
        S_IDX   = 7'b0000100,
        S_READ  = 7'b0001000,
        S_LOAD  = 7'b0010000,
        S_HORN  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic looping_reg;
    logic [NW-1:0] count_reg;
    logic [CW-1:0] mx [MAX_POINTS];
    logic [CW-1:0] my [MAX_POINTS];
    logic [CW-1:0] mz [MAX_POINTS];
    logic [CW-1:0] rx, ry, rz;
    logic signed [CW-1:0] px_reg [4];
    logic signed [CW-1:0] py_reg [4];
    logic signed [CW-1:0] pz_reg [4];
    logic [IW-1:0] idx_reg [4];
    logic [IW-1:0] raddr;
    logic [2:0] rcnt_reg;
    logic [1:0] hcnt_reg;
    logic [TW-1:0] p_reg, t_reg;
    logic [SW-1:0] scaled_reg;
    logic [NW-1:0] segs;
    logic [NW-1:0] seg;
    logic [SW-1:0] segbase;
    logic [NW+1:0] i0, i1, i2, i3, nn;
    logic done_reg;
    logic [1:0] status_reg;
    logic pend_reg;
    logic signed [CW-1:0] ox, oy, oz;

    assign busy = (state_reg != S_IDLE);
    assign nn   = (NW+2)'(count_reg);
    assign segs = looping_reg ? count_reg : count_reg - NW'(1);

    always_comb
    begin
        seg = NW'(scaled_reg >> 16);
        if (seg >= segs)
            seg = segs - NW'(1);
        segbase = SW'(seg) << 16;
        if (looping_reg)
        begin
            i0 = (seg == '0) ? nn - (NW+2)'(1) : (NW+2)'(seg) - (NW+2)'(1);
            i1 = (NW+2)'(seg);
            i2 = i1 + (NW+2)'(1);
            if (i2 >= nn) i2 = i2 - nn;
            i3 = i2 + (NW+2)'(1);
            if (i3 >= nn) i3 = i3 - nn;
        end
        else
        begin
            i0 = (seg == '0) ? '0 : (NW+2)'(seg) - (NW+2)'(1);
            i1 = (NW+2)'(seg);
            i2 = i1 + (NW+2)'(1);
            if (i2 >= nn) i2 = nn - (NW+2)'(1);
            i3 = i1 + (NW+2)'(2);
            if (i3 >= nn) i3 = nn - (NW+2)'(1);
        end
    end

    assign raddr = idx_reg[rcnt_reg[1:0]];

    always_ff @(posedge clk)
    begin
        if (start && !busy && command == crpp_pkg::CMD_APPEND
            && count_reg < NW'(MAX_POINTS))
        begin
            mx[count_reg[IW-1:0]] <= point_x;
            my[count_reg[IW-1:0]] <= point_y;
            mz[count_reg[IW-1:0]] <= point_z;
        end
        rx <= mx[raddr];
        ry <= my[raddr];
        rz <= mz[raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (start && command == crpp_pkg::CMD_QUERY
                    && count_reg >= NW'(4))
                    state_next = S_SCALE;
            S_SCALE: state_next = S_IDX;
            S_IDX:   state_next = S_READ;
            S_READ:  if (rcnt_reg == 3'd4) state_next = S_LOAD;
            S_LOAD:  state_next = S_HORN;
            S_HORN:  if (hcnt_reg == 2'd2) state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            looping_reg <= 1'b0;
            count_reg   <= '0;
            done_reg    <= 1'b0;
            rcnt_reg    <= '0;
            hcnt_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_IDLE && start && state_next == S_IDLE)
                         || (state_reg == S_OUT);
            if (cfg_we)
                looping_reg <= cfg_data;
            if (state_reg == S_IDLE && start)
            begin
                if (command == crpp_pkg::CMD_CLEAR)
                    count_reg <= '0;
                else if (command == crpp_pkg::CMD_APPEND
                         && count_reg < NW'(MAX_POINTS))
                    count_reg <= count_reg + NW'(1);
            end
            rcnt_reg <= (state_reg == S_READ) ? rcnt_reg + 3'd1 : '0;
            hcnt_reg <= (state_reg == S_HORN) ? hcnt_reg + 2'd1 : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            if (progress[crpp_pkg::PROG_W-1])
                p_reg <= '0;
            else if (progress > $signed({1'b0, crpp_pkg::ONE_Q16}))
                p_reg <= crpp_pkg::ONE_Q16;
            else
                p_reg <= TW'(progress);
            case (command)
                crpp_pkg::CMD_CLEAR:  status_reg <= crpp_pkg::ST_DONE;
                crpp_pkg::CMD_APPEND: status_reg <= (count_reg < NW'(MAX_POINTS))
                                      ? crpp_pkg::ST_DONE : crpp_pkg::ST_FULL;
                crpp_pkg::CMD_QUERY:  status_reg <= (count_reg >= NW'(4))
                                      ? crpp_pkg::ST_VALID : crpp_pkg::ST_FEW;
                default:              status_reg <= crpp_pkg::ST_DONE;
            endcase
            pend_reg <= 1'b0;
        end
        if (state_reg == S_SCALE)
            scaled_reg <= SW'(p_reg) * SW'(segs);
        if (state_reg == S_IDX)
        begin
            idx_reg[0] <= IW'(i0);
            idx_reg[1] <= IW'(i1);
            idx_reg[2] <= IW'(i2);
            idx_reg[3] <= IW'(i3);
            t_reg <= ((scaled_reg - segbase) > SW'(crpp_pkg::ONE_Q16))
                     ? crpp_pkg::ONE_Q16 : TW'(scaled_reg - segbase);
        end
        if (state_reg == S_READ && rcnt_reg != 3'd0)
        begin
            px_reg[rcnt_reg[1:0] - 2'd1] <= rx;
            py_reg[rcnt_reg[1:0] - 2'd1] <= ry;
            pz_reg[rcnt_reg[1:0] - 2'd1] <= rz;
        end
        if (state_reg == S_OUT)
            pend_reg <= 1'b1;
    end

    crpp_axis #(.CW(CW)) u_ax (
        .clk(clk), .load(state_reg == S_LOAD), .step(state_reg == S_HORN),
        .p0(px_reg[0]), .p1(px_reg[1]), .p2(px_reg[2]), .p3(px_reg[3]),
        .t(t_reg), .sel(hcnt_reg), .pos(ox));
    crpp_axis #(.CW(CW)) u_ay (
        .clk(clk), .load(state_reg == S_LOAD), .step(state_reg == S_HORN),
        .p0(py_reg[0]), .p1(py_reg[1]), .p2(py_reg[2]), .p3(py_reg[3]),
        .t(t_reg), .sel(hcnt_reg), .pos(oy));
    crpp_axis #(.CW(CW)) u_az (
        .clk(clk), .load(state_reg == S_LOAD), .step(state_reg == S_HORN),
        .p0(pz_reg[0]), .p1(pz_reg[1]), .p2(pz_reg[2]), .p3(pz_reg[3]),
        .t(t_reg), .sel(hcnt_reg), .pos(oz));

    // position only after a full query; otherwise zero
    assign done   = done_reg;
    assign status = status_reg;
    assign pos_x  = (pend_reg && status_reg == crpp_pkg::ST_VALID) ? ox : '0;
    assign pos_y  = (pend_reg && status_reg == crpp_pkg::ST_VALID) ? oy : '0;
    assign pos_z  = (pend_reg && status_reg == crpp_pkg::ST_VALID) ? oz : '0;
endmodule
`default_nettype wire

@@ rtl/core/crpp_axis.sv @@
`default_nettype none
// One axis: coefficients, three Horner steps, one each step-high cycle.
module crpp_axis #(
    parameter int CW = crpp_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       load,
    input  wire logic                       step,
    input  wire logic signed [CW-1:0]       p0,
    input  wire logic signed [CW-1:0]       p1,
    input  wire logic signed [CW-1:0]       p2,
    input  wire logic signed [CW-1:0]       p3,
    input  wire logic [crpp_pkg::T_W-1:0]   t,
    input  wire logic [1:0]                 sel,
    output logic signed [CW-1:0]            pos
);
    // coefficients need CW+4 bits; accumulator a few more for t up to 1
    localparam int CWC = CW + 4;
    localparam int AW  = CW + 6;
    localparam int PW  = AW + crpp_pkg::T_W + 1;

    logic signed [CWC-1:0] c0_reg, c1_reg, c2_reg;
    logic signed [AW-1:0]  a_reg, a_next;
    logic signed [CWC-1:0] e0, e1, e2, e3, cadd;
    logic signed [PW-1:0]  prod;
    logic signed [AW:0]    r;
    logic signed [AW-1:0]  hi, lo;

    assign e0 = CWC'(p0);
    assign e1 = CWC'(p1);
    assign e2 = CWC'(p2);
    assign e3 = CWC'(p3);

    always_comb
    begin
        case (sel)
            2'd0:    cadd = c2_reg;
            2'd1:    cadd = c1_reg;
            default: cadd = c0_reg;
        endcase
        prod   = PW'(a_reg) * $signed({1'b0, t});
        a_next = AW'(prod >>> 16) + AW'(cadd);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            c0_reg <= e1 <<< 1;
            c1_reg <= e2 - e0;
            c2_reg <= (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
            a_reg  <= AW'(-e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3);
        end
        else if (step)
            a_reg <= a_next;
    end

    assign hi = AW'({1'b0, {(CW-1){1'b1}}});
    assign lo = -hi - AW'(1);
    always_comb
    begin
        r = ($signed({a_reg[AW-1], a_reg}) + (AW+1)'(1)) >>> 1;
        if (r > (AW+1)'(hi))
            pos = hi[CW-1:0];
        else if (r < (AW+1)'(lo))
            pos = lo[CW-1:0];
        else
            pos = r[CW-1:0];
    end
endmodule
`default_nettype wire

@@ tb/sv/tb_catmull_rom_path_position.sv @@
`default_nettype none
module tb_catmull_rom_path_position;
    localparam int NPTS = 64;
    localparam int CW   = 32;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic [1:0]           cmd;
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [CW-1:0] pz;
        logic signed [17:0]   prog;
        logic                 hold;     // wait for all results before this transfer
    } cmd_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic [1:0]           st;
    } pos_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_data = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] command = crpp_pkg::CMD_CLEAR;
    logic signed [CW-1:0] point_x = '0, point_y = '0, point_z = '0;
    logic signed [crpp_pkg::PROG_W-1:0] progress = '0;
    logic done;
    logic signed [CW-1:0] pos_x, pos_y, pos_z;
    logic [1:0] status;

    catmull_rom_path_position dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .start(start), .busy(busy), .command(command),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .progress(progress), .done(done), .pos_x(pos_x), .pos_y(pos_y),
        .pos_z(pos_z), .status(status)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor state
    longint xs [NPTS];
    longint ys [NPTS];
    longint zs [NPTS];
    int     n_pts = 0;
    bit     loop_mode = 1'b0;

    cmd_t   pending_cmds [$];
    pos_t   expected_pos [$];
    int     errors = 0;
    int     cycles = 0;
    int     gap = 0;
    bit     no_idle = 1'b0;
    bit     feeding = 1'b0;

    function automatic longint fdiv2pow(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -((-(v + 1)) >>> s) - 1;
    endfunction

    function automatic longint scale_t(longint a, longint t);
        longint q, r;
        q = fdiv2pow(a, 16);
        r = a - q * 65536;
        return q * t + ((r * t) >>> 16);
    endfunction

    function automatic logic [CW-1:0] spline_axis(longint p0, longint p1, longint p2,
                                                  longint p3, longint t);
        longint a, r;
        a = -p0 + 3 * p1 - 3 * p2 + p3;
        a = scale_t(a, t) + (2 * p0 - 5 * p1 + 4 * p2 - p3);
        a = scale_t(a, t) + (p2 - p0);
        a = scale_t(a, t) + 2 * p1;
        r = fdiv2pow(a + 1, 1);
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[CW-1:0];
    endfunction

    function automatic pos_t path_position(cmd_t c);
        pos_t o;
        longint pr, p, segs, sc, seg, t;
        longint i0, i1, i2, i3;
        o = '{x: '0, y: '0, z: '0, st: crpp_pkg::ST_DONE};
        if (c.cmd == crpp_pkg::CMD_CLEAR)
            n_pts = 0;
        else if (c.cmd == crpp_pkg::CMD_APPEND)
        begin
            if (n_pts >= NPTS)
                o.st = crpp_pkg::ST_FULL;
            else
            begin
                xs[n_pts] = c.px;
                ys[n_pts] = c.py;
                zs[n_pts] = c.pz;
                n_pts++;
            end
        end
        else if (c.cmd == crpp_pkg::CMD_QUERY)
        begin
            if (n_pts < 4)
                o.st = crpp_pkg::ST_FEW;
            else
            begin
                pr = c.prog;
                p = pr < 0 ? 0 : (pr > 65536 ? 65536 : pr);
                segs = loop_mode ? n_pts : n_pts - 1;
                sc = p * segs;
                seg = sc >> 16;
                if (seg >= segs)
                    seg = segs - 1;
                t = sc - seg * 65536;
                if (t > 65536)
                    t = 65536;
                if (loop_mode)
                begin
                    i0 = (seg + n_pts - 1) % n_pts;
                    i1 = seg % n_pts;
                    i2 = (seg + 1) % n_pts;
                    i3 = (seg + 2) % n_pts;
                end
                else
                begin
                    i0 = seg > 0 ? seg - 1 : 0;
                    i1 = seg;
                    i2 = seg + 1 >= n_pts ? n_pts - 1 : seg + 1;
                    i3 = seg + 2 >= n_pts ? n_pts - 1 : seg + 2;
                end
                o.x = spline_axis(xs[i0], xs[i1], xs[i2], xs[i3], t);
                o.y = spline_axis(ys[i0], ys[i1], ys[i2], ys[i3], t);
                o.z = spline_axis(zs[i0], zs[i1], zs[i2], zs[i3], t);
                o.st = crpp_pkg::ST_VALID;
            end
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge clk)
    begin
        cmd_t c_now;
        cycles <= cycles + 1;
        if (rst_n && feeding)
        begin
            if (start && !busy)
            begin
                c_now = pending_cmds.pop_front();
                expected_pos = {expected_pos, path_position(c_now)};
                if (!no_idle && $urandom_range(0, 7) == 0)
                    gap = $urandom_range(1, 12);
            end
            if (gap > 0)
            begin
                gap = gap - 1;
                start <= 1'b0;
            end
            else if (pending_cmds.size() > 0 &&
                     !(pending_cmds[0].hold && (expected_pos.size() > 0 || start)))
            begin
                start    <= 1'b1;
                command  <= pending_cmds[0].cmd;
                point_x  <= pending_cmds[0].px;
                point_y  <= pending_cmds[0].py;
                point_z  <= pending_cmds[0].pz;
                progress <= pending_cmds[0].prog;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        pos_t e;
        if (rst_n && done)
        begin
            if (expected_pos.size() == 0)
                report_mismatch("unexpected result, status", status, -1);
            else
            begin
                e = expected_pos.pop_front();
                if (status !== e.st)
                    report_mismatch("status", status, e.st);
                if (pos_x !== e.x)
                    report_mismatch("pos_x", pos_x, e.x);
                if (pos_y !== e.y)
                    report_mismatch("pos_y", pos_y, e.y);
                if (pos_z !== e.z)
                    report_mismatch("pos_z", pos_z, e.z);
            end
        end
        if (cycles > LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom;
            default: return $signed($urandom_range(0, 40 << 16)) - (20 << 16);
        endcase
    endfunction

    function automatic logic [17:0] rand_prog();
        case ($urandom_range(0, 9))
            0: return 18'h1ffff;
            1: return 18'h20000;
            2: return 18'h10000;
            3: return '0;
            4: return 18'($urandom);
            default: return 18'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic add_cmd(logic [1:0] c, logic [17:0] pg, bit h);
        cmd_t k;
        k.cmd = c;
        k.px = rand_coord();
        k.py = rand_coord();
        k.pz = rand_coord();
        k.prog = pg;
        k.hold = h;
        pending_cmds = {pending_cmds, k};
    endtask

    // let the whole queue drain, then write looping while idle
    task automatic drain_and_set_loop(bit v);
        while (pending_cmds.size() > 0 || expected_pos.size() > 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        loop_mode = v;
    endtask

    task automatic random_phase(int count);
        int n, k;
        n = 0;
        while (n < count)
        begin
            k = $urandom_range(0, 19);
            if (k == 0)
                add_cmd(crpp_pkg::CMD_CLEAR, '0, 1'b0);
            else if (k < 8)
                add_cmd(crpp_pkg::CMD_APPEND, 18'($urandom), 1'b0);
            else if (k == 8)
                add_cmd(crpp_pkg::CMD_RSVD, 18'($urandom), 1'b0);
            else
                add_cmd(crpp_pkg::CMD_QUERY, rand_prog(),
                        k == 9 && $urandom_range(0, 9) == 0);
            n++;
        end
    endtask

    initial
    begin
        int i;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        feeding = 1'b1;
        // directed: too few points, bad code, extremes, full store
        add_cmd(crpp_pkg::CMD_QUERY, 18'h08000, 1'b0);
        add_cmd(crpp_pkg::CMD_RSVD, '0, 1'b0);
        for (i = 0; i < 5; i++)
            add_cmd(crpp_pkg::CMD_APPEND, '0, 1'b0);
        add_cmd(crpp_pkg::CMD_QUERY, 18'h20000, 1'b0);
        add_cmd(crpp_pkg::CMD_QUERY, 18'h1ffff, 1'b0);
        add_cmd(crpp_pkg::CMD_QUERY, 18'h10000, 1'b0);
        add_cmd(crpp_pkg::CMD_QUERY, 18'h00000, 1'b0);
        add_cmd(crpp_pkg::CMD_QUERY, 18'h0c000, 1'b1);
        add_cmd(crpp_pkg::CMD_CLEAR, '0, 1'b0);
        drain_and_set_loop(1'b1);
        for (i = 0; i < 66; i++)
            add_cmd(crpp_pkg::CMD_APPEND, '0, 1'b0);
        add_cmd(crpp_pkg::CMD_QUERY, 18'h10000, 1'b0);
        add_cmd(crpp_pkg::CMD_QUERY, 18'h0ffff, 1'b0);
        add_cmd(crpp_pkg::CMD_CLEAR, '0, 1'b0);
        drain_and_set_loop(1'b0);
        random_phase(600);
        drain_and_set_loop(1'b1);
        random_phase(600);
        drain_and_set_loop(1'b0);
        random_phase(400);
        drain_and_set_loop(1'b1);
        no_idle = 1'b1;
        random_phase(400);
        while (pending_cmds.size() > 0 || expected_pos.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
rtl/core/crpp_pkg.sv
rtl/core/crpp_axis.sv
rtl/core/catmull_rom_path_position.sv
tb/sv/tb_catmull_rom_path_position.sv
